// File: hdl/assert_macros.svh
// Assertion helpers used by the RTL top level of the camera basis block.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked out of reset.
`define CB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication that also holds while reset is applied.
`define CB_ASSERT_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CB_ASSERT_NXT(lbl, clk, ante, cons)
`endif
`endif

// File: hdl/cbyp_pkg.sv
// Shared types and constants for the camera basis block.
// No dependencies; used by every module in this folder.
package cbyp_pkg;
  localparam int VW           = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;

  typedef logic signed [VW-1:0] comp_t;
  typedef comp_t [2:0] vec_t;

  localparam comp_t CORDIC_GAIN = 34'sd652032874;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_UP_X = 2'd0;
  localparam logic [1:0] REG_UP_Y = 2'd1;
  localparam logic [1:0] REG_UP_Z = 2'd2;

  // Quadrant codes taken from the top two phase bits.
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  typedef struct packed {
    comp_t      x;
    comp_t      y;
    comp_t      z;
    logic [1:0] quad;
  } rot_t;
  typedef rot_t [1:0] rot2_t;

  typedef struct packed {
    logic [31:0]       len;
    logic [2:0][31:0]  rem;
    logic [2:0][30:0]  nlow;
    logic [2:0][30:0]  quo;
  } div_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic comp_t atan_entry(input int idx);
    comp_t a;
    unique case (idx)
      0:  a = 34'sh20000000;
      1:  a = 34'sh12E4051E;
      2:  a = 34'sh09FB385B;
      3:  a = 34'sh051111D4;
      4:  a = 34'sh028B0D43;
      5:  a = 34'sh0145D7E1;
      6:  a = 34'sh00A2F61E;
      7:  a = 34'sh00517C55;
      8:  a = 34'sh0028BE53;
      9:  a = 34'sh00145F2F;
      10: a = 34'sh000A2F98;
      11: a = 34'sh000517CC;
      12: a = 34'sh00028BE6;
      13: a = 34'sh000145F3;
      14: a = 34'sh0000A2FA;
      15: a = 34'sh0000517D;
      16: a = 34'sh000028BE;
      17: a = 34'sh0000145F;
      18: a = 34'sh00000A30;
      19: a = 34'sh00000518;
      20: a = 34'sh0000028C;
      21: a = 34'sh00000146;
      22: a = 34'sh000000A3;
      23: a = 34'sh00000051;
      24: a = 34'sh00000029;
      25: a = 34'sh00000014;
      26: a = 34'sh0000000A;
      27: a = 34'sh00000005;
      28: a = 34'sh00000003;
      29: a = 34'sh00000001;
      default: a = '0;
    endcase
    return a;
  endfunction
endpackage

// File: hdl/cbyp_cordic_cell.sv
// One rotation step of the yaw and pitch CORDIC chains.
// Depends on cbyp_pkg.
module cbyp_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld_in,
  input  cbyp_pkg::rot2_t rot_in,
  output logic            vld_out,
  output cbyp_pkg::rot2_t rot_out
);
  import cbyp_pkg::*;

  localparam comp_t ANG = atan_entry(STEP);

  logic  vld_r;
  rot2_t rot_r;
  rot2_t rot_nxt;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      rot_nxt[a].quad = rot_in[a].quad;
      if (!rot_in[a].z[VW-1]) begin
        rot_nxt[a].x = $signed(rot_in[a].x) - ($signed(rot_in[a].y) >>> STEP);
        rot_nxt[a].y = $signed(rot_in[a].y) + ($signed(rot_in[a].x) >>> STEP);
        rot_nxt[a].z = $signed(rot_in[a].z) - ANG;
      end else begin
        rot_nxt[a].x = $signed(rot_in[a].x) + ($signed(rot_in[a].y) >>> STEP);
        rot_nxt[a].y = $signed(rot_in[a].y) - ($signed(rot_in[a].x) >>> STEP);
        rot_nxt[a].z = $signed(rot_in[a].z) + ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
  end

  assign vld_out = vld_r;
  assign rot_out = rot_r;
endmodule

// File: hdl/cbyp_sqrt_cell.sv
// One result bit of the integer square root, with side data carried along.
// Depends on cbyp_pkg.
module cbyp_sqrt_cell #(
  parameter int STEP = 0,
  parameter int CW   = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_in,
  input  logic [63:0]   n_in,
  input  logic [63:0]   res_in,
  input  logic [CW-1:0] cargo_in,
  output logic          vld_out,
  output logic [63:0]   n_out,
  output logic [63:0]   res_out,
  output logic [CW-1:0] cargo_out
);
  import cbyp_pkg::*;

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic          vld_r;
  logic [63:0]   n_r, res_r, n_nxt, res_nxt, trial;
  logic [CW-1:0] cargo_r;

  always_comb begin
    trial = res_in + BIT;
    if (n_in >= trial) begin
      n_nxt   = n_in - trial;
      res_nxt = (res_in >> 1) + BIT;
    end else begin
      n_nxt   = n_in;
      res_nxt = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    res_r   <= res_nxt;
    cargo_r <= cargo_in;
  end

  assign vld_out   = vld_r;
  assign n_out     = n_r;
  assign res_out   = res_r;
  assign cargo_out = cargo_r;
endmodule

// File: hdl/cbyp_div_cell.sv
// One quotient bit of three restoring divisions that share a divisor.
// Depends on cbyp_pkg.
module cbyp_div_cell #(
  parameter int CW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_in,
  input  cbyp_pkg::div_t div_in,
  input  logic [CW-1:0]  cargo_in,
  output logic           vld_out,
  output cbyp_pkg::div_t div_out,
  output logic [CW-1:0]  cargo_out
);
  import cbyp_pkg::*;

  logic             vld_r;
  div_t             div_r, div_nxt;
  logic [CW-1:0]    cargo_r;
  logic [2:0][32:0] trial;
  logic [2:0]       ge;

  always_comb begin
    div_nxt = div_in;
    for (int i = 0; i < 3; i++) begin
      trial[i] = {div_in.rem[i], div_in.nlow[i][30]};
      ge[i]    = trial[i] >= {1'b0, div_in.len};
      div_nxt.rem[i]  = ge[i] ? 32'(trial[i] - {1'b0, div_in.len}) : trial[i][31:0];
      div_nxt.nlow[i] = {div_in.nlow[i][29:0], 1'b0};
      div_nxt.quo[i]  = {div_in.quo[i][29:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    div_r   <= div_nxt;
    cargo_r <= cargo_in;
  end

  assign vld_out   = vld_r;
  assign div_out   = div_r;
  assign cargo_out = cargo_r;
endmodule

// File: hdl/cbyp_norm.sv
// Pipelined vector normalizer: squares, sum, root chain, divider chain, clamp.
// Depends on cbyp_pkg, cbyp_sqrt_cell and cbyp_div_cell.
module cbyp_norm #(
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_in,
  input  cbyp_pkg::vec_t vec_in,
  input  logic [SW-1:0]  side_in,
  output logic           vld_out,
  output cbyp_pkg::vec_t vec_out,
  output logic [31:0]    len_out,
  output logic [SW-1:0]  side_out
);
  import cbyp_pkg::*;

  localparam int SQ_CW = SW + 3 + 3 * 32;
  localparam int DV_CW = SW + 4;
  localparam logic [30:0] ONE30 = 31'h40000000;

  // Squares and magnitudes.
  logic                    vld_a_r;
  logic [2:0][63:0]        sq_a_r, sq_a_nxt;
  logic [2:0][31:0]        mag_a_r, mag_a_nxt;
  logic [2:0]              neg_a_r, neg_a_nxt;
  logic [SW-1:0]           side_a_r;
  logic [2:0][2*VW-1:0]    prod;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]      = $signed(vec_in[i]) * $signed(vec_in[i]);
      sq_a_nxt[i]  = prod[i][63:0];
      neg_a_nxt[i] = vec_in[i][VW-1];
      mag_a_nxt[i] = vec_in[i][VW-1] ? 32'(-vec_in[i]) : 32'(vec_in[i]);
    end
  end

  // Sum of squares.
  logic                    vld_b_r;
  logic [63:0]             sum_b_r;
  logic [2:0][31:0]        mag_b_r;
  logic [2:0]              neg_b_r;
  logic [SW-1:0]           side_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= vld_in;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_a_r   <= sq_a_nxt;
    mag_a_r  <= mag_a_nxt;
    neg_a_r  <= neg_a_nxt;
    side_a_r <= side_in;
    sum_b_r  <= sq_a_r[0] + sq_a_r[1] + sq_a_r[2];
    mag_b_r  <= mag_a_r;
    neg_b_r  <= neg_a_r;
    side_b_r <= side_a_r;
  end

  // Square root chain.
  logic [SQRT_STEPS:0] sq_vld;
  logic [63:0]         sq_n     [SQRT_STEPS+1];
  logic [63:0]         sq_res   [SQRT_STEPS+1];
  logic [SQ_CW-1:0]    sq_cargo [SQRT_STEPS+1];

  assign sq_vld[0]   = vld_b_r;
  assign sq_n[0]     = sum_b_r;
  assign sq_res[0]   = '0;
  assign sq_cargo[0] = {side_b_r, neg_b_r, mag_b_r};

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    cbyp_sqrt_cell #(.STEP(j), .CW(SQ_CW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .vld_in    (sq_vld[j]),
      .n_in      (sq_n[j]),
      .res_in    (sq_res[j]),
      .cargo_in  (sq_cargo[j]),
      .vld_out   (sq_vld[j+1]),
      .n_out     (sq_n[j+1]),
      .res_out   (sq_res[j+1]),
      .cargo_out (sq_cargo[j+1])
    );
  end

  // Dividend set-up: |v| * 2^30 + len / 2, split into the first partial
  // remainder and the bits still to be brought down.
  logic [31:0]      len_d;
  logic [2:0][31:0] mag_d;
  logic [2:0]       neg_d;
  logic [SW-1:0]    side_d;
  logic [2:0][63:0] dvd_d;
  div_t             div_d_nxt;

  always_comb begin
    len_d  = sq_res[SQRT_STEPS][31:0];
    mag_d  = sq_cargo[SQRT_STEPS][95:0];
    neg_d  = sq_cargo[SQRT_STEPS][98:96];
    side_d = sq_cargo[SQRT_STEPS][SQ_CW-1:99];
    div_d_nxt.len = len_d;
    for (int i = 0; i < 3; i++) begin
      dvd_d[i] = ({32'd0, mag_d[i]} << 30) + {33'd0, len_d[31:1]};
      div_d_nxt.rem[i]  = dvd_d[i][62:31];
      div_d_nxt.nlow[i] = dvd_d[i][30:0];
      div_d_nxt.quo[i]  = '0;
    end
  end

  logic [DIV_STEPS:0] dv_vld;
  div_t               dv_data  [DIV_STEPS+1];
  logic [DV_CW-1:0]   dv_cargo [DIV_STEPS+1];
  logic               vld_d_r;
  div_t               div_d_r;
  logic [DV_CW-1:0]   cargo_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else begin
      vld_d_r <= sq_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    div_d_r   <= div_d_nxt;
    cargo_d_r <= {side_d, (len_d == 32'd0), neg_d};
  end

  assign dv_vld[0]   = vld_d_r;
  assign dv_data[0]  = div_d_r;
  assign dv_cargo[0] = cargo_d_r;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    cbyp_div_cell #(.CW(DV_CW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .vld_in    (dv_vld[k]),
      .div_in    (dv_data[k]),
      .cargo_in  (dv_cargo[k]),
      .vld_out   (dv_vld[k+1]),
      .div_out   (dv_data[k+1]),
      .cargo_out (dv_cargo[k+1])
    );
  end

  // Clamp, restore the sign, and force a zero-length vector to zero.
  logic             vld_f_r;
  vec_t             vec_f_r, vec_f_nxt;
  logic [31:0]      len_f_r;
  logic [SW-1:0]    side_f_r;
  logic [30:0]      qc;
  comp_t            mag_f;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc    = (dv_data[DIV_STEPS].quo[i] > ONE30) ? ONE30 : dv_data[DIV_STEPS].quo[i];
      mag_f = comp_t'({3'b000, qc});
      if (dv_cargo[DIV_STEPS][3]) begin
        vec_f_nxt[i] = '0;
      end else if (dv_cargo[DIV_STEPS][i]) begin
        vec_f_nxt[i] = -mag_f;
      end else begin
        vec_f_nxt[i] = mag_f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_f_r <= 1'b0;
    end else begin
      vld_f_r <= dv_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    vec_f_r  <= vec_f_nxt;
    len_f_r  <= dv_data[DIV_STEPS].len;
    side_f_r <= dv_cargo[DIV_STEPS][DV_CW-1:4];
  end

  assign vld_out  = vld_f_r;
  assign vec_out  = vec_f_r;
  assign len_out  = len_f_r;
  assign side_out = side_f_r;
endmodule

// File: hdl/camera_basis_from_yaw_pitch.sv
// Camera basis from yaw and pitch: forward, right and up unit vectors.
// One start beat is taken in every cycle, so busy stays low. Each beat passes
// the 30-cell CORDIC chain and three normalizers of 67 stages each (32 root,
// 31 divide).
// Synchronous active-low reset clears all valid flags and loads world up (0,1,0).
// Results come as one-cycle strobes that the receiver cannot hold off.
`include "assert_macros.svh"
module camera_basis_from_yaw_pitch #(
  parameter int FRAC_BITS  = 14,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input beats.
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_yaw_angle,
  input  logic [15:0]        in_pitch_angle,
  // Result beats.
  output logic               out_strobe,
  output logic signed [15:0] out_forward_x,
  output logic signed [15:0] out_forward_y,
  output logic signed [15:0] out_forward_z,
  output logic signed [15:0] out_right_x,
  output logic signed [15:0] out_right_y,
  output logic signed [15:0] out_right_z,
  output logic signed [15:0] out_up_x,
  output logic signed [15:0] out_up_y,
  output logic signed [15:0] out_up_z,
  output logic               out_degenerate,
  // Configuration writes.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import cbyp_pkg::*;

  localparam int          SH         = 30 - FRAC_BITS;
  localparam logic [63:0] ANG_MASK   = (64'd1 << ANGLE_BITS) - 64'd1;
  localparam logic [15:0] UP_Y_RESET = 16'(64'd1 << FRAC_BITS);
  localparam comp_t       UP_LIM     = comp_t'(64'sd1 <<< FRAC_BITS);
  localparam comp_t       UP_NLIM    = -UP_LIM;
  localparam logic signed [VW:0] OUT_LIM  = (VW+1)'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [VW:0] OUT_NLIM = -OUT_LIM;
  localparam logic signed [VW:0] HALF     = (SH > 0) ? (VW+1)'(64'sd1 <<< (SH - 1)) : '0;
  localparam logic [31:0] DEGEN_THR  = 32'(64'd1 << SH);

  // Saturate a world up register to one unit and move it to Q30.
  function automatic comp_t up_q30(input logic signed [15:0] raw);
    comp_t v;
    v = VW'(raw);
    if (v > UP_LIM) begin
      v = UP_LIM;
    end else if (v < UP_NLIM) begin
      v = UP_NLIM;
    end
    return v <<< SH;
  endfunction

  // Round Q30 half up to the output format, clamp to one unit, keep 16 bits.
  function automatic logic [15:0] to_out(input comp_t v);
    logic signed [VW:0] t;
    t = {v[VW-1], v};
    t = (t + HALF) >>> SH;
    if (t > OUT_LIM) begin
      t = OUT_LIM;
    end else if (t < OUT_NLIM) begin
      t = OUT_NLIM;
    end
    return t[15:0];
  endfunction

  // The pipeline never stalls, so both ports always take a beat.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // World up registers. Writes to an unused index are dropped.
  logic [15:0] up_x_r, up_y_r, up_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_x_r <= '0;
      up_y_r <= UP_Y_RESET;
      up_z_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_UP_X: up_x_r <= cfg_data;
        REG_UP_Y: up_y_r <= cfg_data;
        REG_UP_Z: up_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The angles become 32-bit phases. The top two bits pick the quadrant and
  // the CORDIC chain turns through the remaining thirty.
  logic [31:0] phase_yaw, phase_pitch;
  logic [CORDIC_STEPS:0] cr_vld;
  rot2_t                 cr_rot [CORDIC_STEPS+1];

  always_comb begin
    phase_yaw   = 32'(({48'd0, in_yaw_angle} & ANG_MASK) << (32 - ANGLE_BITS));
    phase_pitch = 32'(({48'd0, in_pitch_angle} & ANG_MASK) << (32 - ANGLE_BITS));
    cr_vld[0]   = start && !busy;
    cr_rot[0][0].x    = CORDIC_GAIN;
    cr_rot[0][0].y    = '0;
    cr_rot[0][0].z    = comp_t'({4'b0000, phase_yaw[29:0]});
    cr_rot[0][0].quad = phase_yaw[31:30];
    cr_rot[0][1].x    = CORDIC_GAIN;
    cr_rot[0][1].y    = '0;
    cr_rot[0][1].z    = comp_t'({4'b0000, phase_pitch[29:0]});
    cr_rot[0][1].quad = phase_pitch[31:30];
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
    cbyp_cordic_cell #(.STEP(s)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (cr_vld[s]),
      .rot_in  (cr_rot[s]),
      .vld_out (cr_vld[s+1]),
      .rot_out (cr_rot[s+1])
    );
  end

  // Quadrant fix-up: index 0 is yaw, index 1 is pitch.
  logic       vld_q_r;
  comp_t      cos_q_r [2];
  comp_t      sin_q_r [2];
  comp_t      cos_q_nxt [2];
  comp_t      sin_q_nxt [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      unique case (cr_rot[CORDIC_STEPS][a].quad)
        QUAD_I: begin
          cos_q_nxt[a] = cr_rot[CORDIC_STEPS][a].x;
          sin_q_nxt[a] = cr_rot[CORDIC_STEPS][a].y;
        end
        QUAD_II: begin
          cos_q_nxt[a] = -cr_rot[CORDIC_STEPS][a].y;
          sin_q_nxt[a] = cr_rot[CORDIC_STEPS][a].x;
        end
        QUAD_III: begin
          cos_q_nxt[a] = -cr_rot[CORDIC_STEPS][a].x;
          sin_q_nxt[a] = -cr_rot[CORDIC_STEPS][a].y;
        end
        QUAD_IV: begin
          cos_q_nxt[a] = cr_rot[CORDIC_STEPS][a].y;
          sin_q_nxt[a] = -cr_rot[CORDIC_STEPS][a].x;
        end
        default: begin
          cos_q_nxt[a] = '0;
          sin_q_nxt[a] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cos_q_r[0] <= cos_q_nxt[0];
    cos_q_r[1] <= cos_q_nxt[1];
    sin_q_r[0] <= sin_q_nxt[0];
    sin_q_r[1] <= sin_q_nxt[1];
  end

  // Raw forward vector. The products round toward minus infinity. World up is
  // sampled here and travels with the item to the cross product.
  logic                 vld_m_r;
  vec_t                 fwd_m_r, up_m_r;
  logic signed [2*VW-1:0] prod_cc, prod_sc;

  always_comb begin
    prod_cc = $signed(cos_q_r[0]) * $signed(cos_q_r[1]);
    prod_sc = $signed(sin_q_r[0]) * $signed(cos_q_r[1]);
  end

  always_ff @(posedge clk) begin
    fwd_m_r[0] <= VW'(prod_cc >>> 30);
    fwd_m_r[1] <= sin_q_r[1];
    fwd_m_r[2] <= VW'(prod_sc >>> 30);
    up_m_r[0]  <= up_q30(up_x_r);
    up_m_r[1]  <= up_q30(up_y_r);
    up_m_r[2]  <= up_q30(up_z_r);
  end

  // Unit forward.
  logic        vld_n1;
  vec_t        fn_n1, up_n1;
  logic [31:0] len_n1;

  cbyp_norm #(.SW(3 * VW)) u_norm_fwd (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (vld_m_r),
    .vec_in   (fwd_m_r),
    .side_in  (up_m_r),
    .vld_out  (vld_n1),
    .vec_out  (fn_n1),
    .len_out  (len_n1),
    .side_out (up_n1)
  );

  // Right, unnormalized: forward x world up, split over a product stage and a
  // difference stage.
  logic                      vld_x1_r, vld_x2_r;
  logic signed [2*VW-1:0]    px_r [6];
  vec_t                      fn_x1_r, fn_x2_r, rt_x2_r;
  logic                      len1_zero_x1_r;

  always_ff @(posedge clk) begin
    px_r[0] <= $signed(fn_n1[1]) * $signed(up_n1[2]);
    px_r[1] <= $signed(fn_n1[2]) * $signed(up_n1[1]);
    px_r[2] <= $signed(fn_n1[2]) * $signed(up_n1[0]);
    px_r[3] <= $signed(fn_n1[0]) * $signed(up_n1[2]);
    px_r[4] <= $signed(fn_n1[0]) * $signed(up_n1[1]);
    px_r[5] <= $signed(fn_n1[1]) * $signed(up_n1[0]);
    fn_x1_r <= fn_n1;
    len1_zero_x1_r <= (len_n1 == 32'd0);
    for (int i = 0; i < 3; i++) begin
      rt_x2_r[i] <= VW'((px_r[2*i] - px_r[2*i+1]) >>> 30);
    end
    fn_x2_r <= fn_x1_r;
  end

  // Unit right, with forward riding along.
  logic        vld_n2;
  vec_t        rn_n2, fn_n2;
  logic [31:0] len_n2;

  cbyp_norm #(.SW(3 * VW)) u_norm_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (vld_x2_r),
    .vec_in   (rt_x2_r),
    .side_in  (fn_x2_r),
    .vld_out  (vld_n2),
    .vec_out  (rn_n2),
    .len_out  (len_n2),
    .side_out (fn_n2)
  );

  // Up, unnormalized: right x forward. A right vector shorter than one output
  // step marks the item degenerate; its right and up are zeroed at the end.
  logic                   vld_y1_r, vld_y2_r;
  logic signed [2*VW-1:0] py_r [6];
  vec_t                   fn_y1_r, rn_y1_r, fn_y2_r, rn_y2_r, up_y2_r;
  logic                   dg_y1_r, dg_y2_r;

  always_ff @(posedge clk) begin
    py_r[0] <= $signed(rn_n2[1]) * $signed(fn_n2[2]);
    py_r[1] <= $signed(rn_n2[2]) * $signed(fn_n2[1]);
    py_r[2] <= $signed(rn_n2[2]) * $signed(fn_n2[0]);
    py_r[3] <= $signed(rn_n2[0]) * $signed(fn_n2[2]);
    py_r[4] <= $signed(rn_n2[0]) * $signed(fn_n2[1]);
    py_r[5] <= $signed(rn_n2[1]) * $signed(fn_n2[0]);
    fn_y1_r <= fn_n2;
    rn_y1_r <= rn_n2;
    dg_y1_r <= len_n2 < DEGEN_THR;
    for (int i = 0; i < 3; i++) begin
      up_y2_r[i] <= VW'((py_r[2*i] - py_r[2*i+1]) >>> 30);
    end
    fn_y2_r <= fn_y1_r;
    rn_y2_r <= rn_y1_r;
    dg_y2_r <= dg_y1_r;
  end

  // Unit up, with degenerate, forward and right riding along.
  logic               vld_n3;
  vec_t               un_n3, fn_n3, rn_n3;
  logic [31:0]        len_n3;
  logic [6*VW:0]      side_n3;

  cbyp_norm #(.SW(6 * VW + 1)) u_norm_up (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (vld_y2_r),
    .vec_in   (up_y2_r),
    .side_in  ({dg_y2_r, fn_y2_r, rn_y2_r}),
    .vld_out  (vld_n3),
    .vec_out  (un_n3),
    .len_out  (len_n3),
    .side_out (side_n3)
  );

  assign fn_n3 = side_n3[6*VW-1:3*VW];
  assign rn_n3 = side_n3[3*VW-1:0];

  // Control flags of the glue stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_q_r  <= 1'b0;
      vld_m_r  <= 1'b0;
      vld_x1_r <= 1'b0;
      vld_x2_r <= 1'b0;
      vld_y1_r <= 1'b0;
      vld_y2_r <= 1'b0;
    end else begin
      vld_q_r  <= cr_vld[CORDIC_STEPS];
      vld_m_r  <= vld_q_r;
      vld_x1_r <= vld_n1;
      vld_x2_r <= vld_x1_r;
      vld_y1_r <= vld_n2;
      vld_y2_r <= vld_y1_r;
    end
  end

  // Output register: one strobe per item, masked right and up when degenerate.
  logic        out_strobe_r, degen_o;
  logic [15:0] out_fx_r, out_fy_r, out_fz_r;
  logic [15:0] out_rx_r, out_ry_r, out_rz_r;
  logic [15:0] out_ux_r, out_uy_r, out_uz_r;
  logic        out_dg_r;

  assign degen_o = side_n3[6*VW] || (len_n3 == 32'd0 && 1'b0) || (len1_zero_x1_r && 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_n3;
    end
  end

  always_ff @(posedge clk) begin
    out_fx_r <= to_out(fn_n3[0]);
    out_fy_r <= to_out(fn_n3[1]);
    out_fz_r <= to_out(fn_n3[2]);
    out_rx_r <= degen_o ? 16'd0 : to_out(rn_n3[0]);
    out_ry_r <= degen_o ? 16'd0 : to_out(rn_n3[1]);
    out_rz_r <= degen_o ? 16'd0 : to_out(rn_n3[2]);
    out_ux_r <= degen_o ? 16'd0 : to_out(un_n3[0]);
    out_uy_r <= degen_o ? 16'd0 : to_out(un_n3[1]);
    out_uz_r <= degen_o ? 16'd0 : to_out(un_n3[2]);
    out_dg_r <= degen_o;
  end

  assign out_strobe     = out_strobe_r;
  assign out_forward_x  = out_fx_r;
  assign out_forward_y  = out_fy_r;
  assign out_forward_z  = out_fz_r;
  assign out_right_x    = out_rx_r;
  assign out_right_y    = out_ry_r;
  assign out_right_z    = out_rz_r;
  assign out_up_x       = out_ux_r;
  assign out_up_y       = out_uy_r;
  assign out_up_z       = out_uz_r;
  assign out_degenerate = out_dg_r;

  // A degenerate item carries no right vector and no up vector.
  `CB_ASSERT_IMP(a_degen_right, clk, rst_n, out_strobe && out_degenerate, (out_right_x == 16'sd0) && (out_right_y == 16'sd0) && (out_right_z == 16'sd0))
  `CB_ASSERT_IMP(a_degen_up, clk, rst_n, out_strobe && out_degenerate, (out_up_x == 16'sd0) && (out_up_y == 16'sd0) && (out_up_z == 16'sd0))
  // Reset empties the whole pipeline, so no strobe follows a reset cycle.
  `CB_ASSERT_NXT(a_reset_flush, clk, !rst_n, !out_strobe)
endmodule

// File: verif/camera_basis_from_yaw_pitch_tb.sv
// Testbench for camera_basis_from_yaw_pitch: drives yaw/pitch beats, predicts the basis
// vectors with a local fixed-point model and checks every result beat.
// Depends on the RTL top level and cbyp_pkg for register indexes and quadrant codes.
`timescale 1ns / 100ps
module camera_basis_from_yaw_pitch_tb;
  import cbyp_pkg::*;

  localparam int FRAC = 14;
  localparam int LATENCY = 238;
  localparam int WATCHDOG_LIMIT = 4000;

  // One angle pair per beat, and the basis vectors that it should yield.
  typedef struct {
    logic [15:0] yaw;
    logic [15:0] pitch;
  } angles_t;

  typedef struct {
    logic [15:0] fwd [3];
    logic [15:0] rgt [3];
    logic [15:0] upv [3];
    logic        degen;
  } basis_t;

  typedef longint vec3_t [3];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_yaw_angle = '0;
  logic [15:0] in_pitch_angle = '0;
  logic out_strobe;
  logic signed [15:0] out_forward_x, out_forward_y, out_forward_z;
  logic signed [15:0] out_right_x, out_right_y, out_right_z;
  logic signed [15:0] out_up_x, out_up_y, out_up_z;
  logic out_degenerate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_UP_X;
  logic [15:0] cfg_data = '0;

  camera_basis_from_yaw_pitch u_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_yaw_angle(in_yaw_angle), .in_pitch_angle(in_pitch_angle),
    .out_strobe(out_strobe),
    .out_forward_x(out_forward_x), .out_forward_y(out_forward_y),
    .out_forward_z(out_forward_z),
    .out_right_x(out_right_x), .out_right_y(out_right_y), .out_right_z(out_right_z),
    .out_up_x(out_up_x), .out_up_y(out_up_y), .out_up_z(out_up_z),
    .out_degenerate(out_degenerate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The model's own copy of the world up registers (raw 16-bit words).
  logic [15:0] up_reg [3];

  angles_t pending_angles [$];
  basis_t  expected_basis [$];
  int      sender_idle_pct = 0;
  int      mismatch_count = 0;
  int      stray_count = 0;
  int      quiet_cycles = 0;

  // Arctangent of 2^-i in units of 2^-32 turn.
  const longint ATAN_STEP [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  // The >>> on longint is an arithmetic shift, which floors toward minus infinity.
  function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                  output longint s);
    logic [31:0] phase;
    longint x, y, z, dx, dy;
    phase = {ang, 16'h0};
    x = 64'd652032874;
    y = 0;
    z = longint'(phase[29:0]);
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_STEP[i];
      end else begin
        x += dx; y -= dy; z += ATAN_STEP[i];
      end
    end
    case (phase[31:30])
      QUAD_I:   begin c = x;  s = y;  end
      QUAD_II:  begin c = -y; s = x;  end
      QUAD_III: begin c = -x; s = -y; end
      default:  begin c = y;  s = -x; end
    endcase
  endfunction

  function automatic longint root_floor(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint length_of(input vec3_t v);
    longint unsigned sum, m;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? -v[i] : v[i];
      sum += m * m;
    end
    return root_floor(sum);
  endfunction

  // Scale to unit length with half-up rounding; a zero length gives zero.
  function automatic void unit_scale(input vec3_t v, input longint len, output vec3_t o);
    longint m, r;
    for (int i = 0; i < 3; i++) begin
      if (len <= 0) begin
        o[i] = 0;
      end else begin
        m = (v[i] < 0) ? -v[i] : v[i];
        r = (m * (64'sd1 <<< 30) + len / 2) / len;
        if (r > (64'sd1 <<< 30)) r = 64'sd1 <<< 30;
        o[i] = (v[i] < 0) ? -r : r;
      end
    end
  endfunction

  function automatic void cross_q30(input vec3_t a, input vec3_t b, output vec3_t o);
    o[0] = (a[1] * b[2] - a[2] * b[1]) >>> 30;
    o[1] = (a[2] * b[0] - a[0] * b[2]) >>> 30;
    o[2] = (a[0] * b[1] - a[1] * b[0]) >>> 30;
  endfunction

  // Out-of-range register words saturate to plus or minus one at use.
  function automatic longint up_component_q30(input logic [15:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v > (64'sd1 <<< FRAC)) v = 64'sd1 <<< FRAC;
    if (v < -(64'sd1 <<< FRAC)) v = -(64'sd1 <<< FRAC);
    return v <<< (30 - FRAC);
  endfunction

  function automatic logic [15:0] to_port(input longint v);
    longint r;
    r = (v + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    if (r > (64'sd1 <<< FRAC)) r = 64'sd1 <<< FRAC;
    if (r < -(64'sd1 <<< FRAC)) r = -(64'sd1 <<< FRAC);
    return r[15:0];
  endfunction

  function automatic basis_t camera_basis(input angles_t a);
    basis_t b;
    longint cy, sy, cp, sp;
    vec3_t fw, fwn, wu, rt, rtn, uv, uvn;
    longint rlen;
    sin_cos(a.yaw, cy, sy);
    sin_cos(a.pitch, cp, sp);
    fw[0] = (cy * cp) >>> 30;
    fw[1] = sp;
    fw[2] = (sy * cp) >>> 30;
    unit_scale(fw, length_of(fw), fwn);
    for (int i = 0; i < 3; i++) wu[i] = up_component_q30(up_reg[i]);
    cross_q30(fwn, wu, rt);
    rlen = length_of(rt);
    // Forward parallel to world up, or a zero world up: right and up are zeroed.
    b.degen = rlen < (64'sd1 <<< (30 - FRAC));
    if (b.degen) begin
      for (int i = 0; i < 3; i++) begin
        rtn[i] = 0; uvn[i] = 0;
      end
    end else begin
      unit_scale(rt, rlen, rtn);
      cross_q30(rtn, fwn, uv);
      unit_scale(uv, length_of(uv), uvn);
    end
    for (int i = 0; i < 3; i++) begin
      b.fwd[i] = to_port(fwn[i]);
      b.rgt[i] = to_port(rtn[i]);
      b.upv[i] = to_port(uvn[i]);
    end
    return b;
  endfunction

  // Driver: presents the next pending beat at the falling edge. The expected basis is
  // computed when the beat is accepted, so it always sees the current registers.
  always @(negedge clk) begin
    if (rst_n && start && !busy) begin
      void'(pending_angles.pop_front());
    end
    if (rst_n && pending_angles.size() > 0 &&
        $urandom_range(99) >= sender_idle_pct) begin
      start <= 1'b1;
      in_yaw_angle <= pending_angles[0].yaw;
      in_pitch_angle <= pending_angles[0].pitch;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: records accepted beats and checks each result strobe.
  always @(posedge clk) begin
    basis_t want, got;
    angles_t a;
    if (rst_n) begin
      if (start && !busy) begin
        a.yaw = in_yaw_angle;
        a.pitch = in_pitch_angle;
        expected_basis.push_back(camera_basis(a));
        quiet_cycles <= 0;
      end else if (out_strobe) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_strobe) begin
        got.fwd = '{out_forward_x, out_forward_y, out_forward_z};
        got.rgt = '{out_right_x, out_right_y, out_right_z};
        got.upv = '{out_up_x, out_up_y, out_up_z};
        got.degen = out_degenerate;
        if (expected_basis.size() == 0) begin
          stray_count++;
          $display("unexpected result beat at %0t", $realtime);
        end else begin
          want = expected_basis.pop_front();
          if (got != want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch at %0t: fwd %0d %0d %0d / %0d %0d %0d", $realtime,
                       $signed(want.fwd[0]), $signed(want.fwd[1]), $signed(want.fwd[2]),
                       $signed(got.fwd[0]), $signed(got.fwd[1]), $signed(got.fwd[2]));
              $display("  right %0d %0d %0d / %0d %0d %0d", $signed(want.rgt[0]),
                       $signed(want.rgt[1]), $signed(want.rgt[2]), $signed(got.rgt[0]),
                       $signed(got.rgt[1]), $signed(got.rgt[2]));
              $display("  up %0d %0d %0d / %0d %0d %0d  degen %0b / %0b",
                       $signed(want.upv[0]), $signed(want.upv[1]), $signed(want.upv[2]),
                       $signed(got.upv[0]), $signed(got.upv[1]), $signed(got.upv[2]),
                       want.degen, got.degen);
            end
          end
        end
      end
    end
  end

  // Watchdog: too long with no beat moving ends the run as a failure.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("camera_basis_from_yaw_pitch_tb: errors");
      $finish;
    end
  end

  // One register write; the model copy follows at the accepting edge.
  task automatic write_up(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    up_reg[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_world_up(input logic [15:0] ux, input logic [15:0] uy,
                                input logic [15:0] uz);
    write_up(REG_UP_X, ux);
    write_up(REG_UP_Y, uy);
    write_up(REG_UP_Z, uz);
  endtask

  task automatic queue_angles(input logic [15:0] yaw, input logic [15:0] pitch);
    angles_t a;
    a.yaw = yaw;
    a.pitch = pitch;
    pending_angles.push_back(a);
  endtask

  // Blocks until every queued beat has been taken and every result has come back.
  task automatic drain;
    while (pending_angles.size() > 0 || expected_basis.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random angles, with about a fifth landing on quadrant boundaries and poles,
  // where the CORDIC quadrant fold and the degenerate check are exercised.
  task automatic queue_random(input int n);
    logic [15:0] y, p;
    for (int i = 0; i < n; i++) begin
      y = 16'($urandom_range(16'hFFFF));
      p = 16'($urandom_range(16'hFFFF));
      if ($urandom_range(9) < 2) begin
        p = {2'($urandom_range(3)), 14'h0} + 16'($urandom_range(2)) - 16'd1;
      end
      if ($urandom_range(9) == 0) y = {2'($urandom_range(3)), 14'h0};
      queue_angles(y, p);
    end
  endtask

  initial begin
    up_reg = '{16'h0000, 16'h4000, 16'h0000};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats with the reset world up: axes, poles (degenerate), extremes.
    queue_angles(16'h0000, 16'h0000);
    queue_angles(16'h4000, 16'h0000);
    queue_angles(16'h8000, 16'h0000);
    queue_angles(16'hC000, 16'h0000);
    queue_angles(16'h0000, 16'h4000);
    queue_angles(16'h1234, 16'hC000);
    queue_angles(16'hFFFF, 16'hFFFF);
    queue_angles(16'h0001, 16'h3FFF);
    queue_angles(16'h2000, 16'h4001);
    queue_angles(16'h5555, 16'hAAAA);
    queue_angles(16'h7FFF, 16'h8000);
    queue_angles(16'hFFFF, 16'h0000);
    drain();

    // Zero world up: every beat is degenerate.
    write_world_up(16'h0000, 16'h0000, 16'h0000);
    queue_angles(16'h0000, 16'h0000);
    queue_angles(16'h3000, 16'h1000);
    drain();
    // Out-of-range words saturate at use: both extremes of the 16-bit range.
    write_world_up(16'h7FFF, 16'h8000, 16'h0000);
    queue_angles(16'h2000, 16'hE000);
    queue_angles(16'h0000, 16'h0000);
    queue_angles(16'h6000, 16'h1000);
    drain();
    // World up along x and along -z: yaw 0 / yaw 3/4 turn are parallel.
    write_world_up(16'h4000, 16'h0000, 16'h0000);
    queue_angles(16'h0000, 16'h0000);
    queue_angles(16'h8000, 16'h0000);
    drain();
    write_world_up(16'h0000, 16'h0000, 16'hC000);
    queue_angles(16'hC000, 16'h0000);
    queue_angles(16'h4000, 16'h0000);
    drain();

    // Random phases: sender idle 30% of cycles, then 58%, then back-to-back twice.
    for (int phase_no = 0; phase_no < 4; phase_no++) begin
      sender_idle_pct = (phase_no == 0) ? 30 : (phase_no == 1) ? 58 : 0;
      if (phase_no == 3) write_world_up(16'h0000, 16'h4000, 16'h0000);
      else if (phase_no == 0) write_world_up(16'h2D41, 16'h2D41, 16'h0000);
      else write_world_up(16'($urandom), 16'($urandom), 16'($urandom));
      queue_random(320);
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (mismatch_count == 0 && stray_count == 0 && expected_basis.size() == 0) begin
      $display("camera_basis_from_yaw_pitch_tb: clean");
    end else begin
      $display("camera_basis_from_yaw_pitch_tb: errors");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+hdl
hdl/cbyp_pkg.sv
hdl/cbyp_cordic_cell.sv
hdl/cbyp_sqrt_cell.sv
hdl/cbyp_div_cell.sv
hdl/cbyp_norm.sv
hdl/camera_basis_from_yaw_pitch.sv
verif/camera_basis_from_yaw_pitch_tb.sv
